>>> design/html_to_plain_text_stream_assert.svh
// Assertion macros for the HTML to plain text stream block.
`ifndef HTML_TO_PLAIN_TEXT_STREAM_ASSERT_SVH
`define HTML_TO_PLAIN_TEXT_STREAM_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define H2T_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define H2T_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/h2t_pkg.sv
// Types and constants for the HTML to plain text stream block.
package h2t_pkg;

  localparam int MaxEntitySpan = 12;
  localparam int EntCap        = MaxEntitySpan - 1;
  localparam int EntLenW       = $clog2(EntCap + 1);
  localparam int EntIdxW       = (EntCap > 1) ? $clog2(EntCap) : 1;
  localparam int MaxResults    = 16;
  localparam int ResCntW       = $clog2(MaxResults + 1);
  localparam logic [15:0] SpaceMax = 16'hFFFF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] spaces_before;
    logic        has_byte;
    logic        out_last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_REPLAY,
    S_EMIT,
    S_END
  } h2t_state_e;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == SpaceMax) ? v : v + 16'd1;
  endfunction

endpackage

>>> design/html_to_plain_text_stream.sv
// HTML to plain text stream: tag strip, whitespace collapse, entity decode.
//
//  channel | dir | handshake              | payload
//  in      | in  | in_valid_i/in_ready_o   | in_i  (in_byte, in_last)
//  out     | out | out_valid_o/out_ready_i | out_o (out_byte, spaces_before, has_byte, out_last)
//
// A plain byte goes through accept, process and step end in order; one item at a time.
// An entity flush emits its buffered bytes one by one from the emit state; a replay
// feeds each buffered byte through the single byte-processing step under the sequencer.
// Output stalls hold the sequencer at its next push; the input stays not ready.
// Asynchronous active-low reset returns all parser state to empty.
`include "html_to_plain_text_stream_assert.svh"

module html_to_plain_text_stream (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  h2t_pkg::in_item_t   in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output h2t_pkg::out_item_t  out_o
);
  import h2t_pkg::*;

  h2t_state_e state_q, state_d, ret_q, ret_d;
  logic [7:0] cur_q, cur_d, extra_q, extra_d;
  logic last_q, last_d, extra_v_q, extra_v_d;
  logic in_tag_q, in_tag_d, last_sp_q, last_sp_d, started_q, started_d;
  logic in_ent_q, in_ent_d;
  logic [15:0] pend_q, pend_d;
  logic [EntLenW-1:0] ent_len_q, ent_len_d, rp_len_q, rp_len_d, rp_idx_q, rp_idx_d;
  logic [EntLenW:0] em_idx_q, em_idx_d;
  logic [7:0] buf_q [EntCap];
  logic buf_we;
  logic [7:0] buf_wdata;
  logic [ResCntW-1:0] res_cnt_q, res_cnt_d;
  out_item_t hold_q, hold_d, out_q, out_d;
  logic hold_v_q, hold_v_d, out_v_q, out_v_d;

  logic out_free, can_push, push, proc;
  logic [7:0] pbyte, b;
  logic is_ws, is_amp, is_lt, is_gt, is_quot, is_apos, is_nbsp;

  assign out_free  = !out_v_q || out_ready_i;
  assign can_push  = !hold_v_q || out_free;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  assign is_ws = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
  assign is_amp  = ent_len_q == EntLenW'(3) && buf_q[0] == "a" && buf_q[1] == "m"
                   && buf_q[2] == "p";
  assign is_lt   = ent_len_q == EntLenW'(2) && buf_q[0] == "l" && buf_q[1] == "t";
  assign is_gt   = ent_len_q == EntLenW'(2) && buf_q[0] == "g" && buf_q[1] == "t";
  assign is_quot = ent_len_q == EntLenW'(4) && buf_q[0] == "q" && buf_q[1] == "u"
                   && buf_q[2] == "o" && buf_q[3] == "t";
  assign is_apos = ent_len_q == EntLenW'(4) && buf_q[0] == "a" && buf_q[1] == "p"
                   && buf_q[2] == "o" && buf_q[3] == "s";
  assign is_nbsp = ent_len_q == EntLenW'(4) && buf_q[0] == "n" && buf_q[1] == "b"
                   && buf_q[2] == "s" && buf_q[3] == "p";

  // Byte fed to the shared processing step.
  always_comb begin
    b = cur_q;
    if (state_q == S_REPLAY) begin
      b = (rp_idx_q < rp_len_q) ? buf_q[rp_idx_q[EntIdxW-1:0]] : extra_q;
    end
  end

  always_comb begin
    state_d = state_q; ret_d = ret_q;
    cur_d = cur_q; last_d = last_q; extra_d = extra_q; extra_v_d = extra_v_q;
    in_tag_d = in_tag_q; last_sp_d = last_sp_q; started_d = started_q;
    in_ent_d = in_ent_q; pend_d = pend_q; ent_len_d = ent_len_q;
    rp_len_d = rp_len_q; rp_idx_d = rp_idx_q; em_idx_d = em_idx_q;
    res_cnt_d = res_cnt_q; hold_d = hold_q; hold_v_d = hold_v_q;
    out_d = out_q; out_v_d = out_v_q;
    buf_we = 1'b0; buf_wdata = b;
    push = 1'b0; pbyte = b; proc = 1'b0;

    if (out_v_q && out_ready_i) out_v_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cur_d = in_i.in_byte;
          last_d = in_i.in_last;
          res_cnt_d = '0;
          state_d = S_TAKE;
        end
      end
      S_TAKE, S_REPLAY: begin
        if (state_q == S_REPLAY && rp_idx_q == rp_len_q && !extra_v_q) begin
          state_d = S_END;
        end else begin
          proc = 1'b1;
        end
      end
      S_EMIT: begin
        push = 1'b1;
        if (em_idx_q == '0) pbyte = "&";
        else if (em_idx_q <= {1'b0, ent_len_q}) pbyte = buf_q[em_idx_q[EntIdxW-1:0] - 1'b1];
        else pbyte = ";";
        if (can_push) begin
          em_idx_d = em_idx_q + 1'b1;
          if (em_idx_q == {1'b0, ent_len_q} + 1'b1) begin
            in_ent_d = 1'b0; ent_len_d = '0;
            state_d = ret_q;
          end
        end
      end
      S_END: begin
        if (last_q && in_ent_q) begin
          // document ended inside an entity: give up on it and replay
          push = 1'b1; pbyte = "&";
          if (can_push) begin
            rp_len_d = ent_len_q; rp_idx_d = '0; extra_v_d = 1'b0;
            in_ent_d = 1'b0; ent_len_d = '0;
            state_d = S_REPLAY;
          end
        end else if (last_q) begin
          if (out_free) begin
            if (hold_v_q) begin
              out_d = hold_q; out_d.out_last = 1'b1; out_v_d = 1'b1;
            end else if (res_cnt_q == '0) begin
              out_d = '0; out_d.out_last = 1'b1; out_v_d = 1'b1;
            end
            hold_v_d = 1'b0;
            in_tag_d = 1'b0; last_sp_d = 1'b0; started_d = 1'b0;
            pend_d = '0; in_ent_d = 1'b0; ent_len_d = '0;
            state_d = S_IDLE;
          end
        end else if (!hold_v_q || out_free) begin
          if (hold_v_q) begin
            out_d = hold_q; out_v_d = 1'b1;
          end
          hold_v_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Shared byte-processing step.
    if (proc) begin
      if (in_ent_q) begin
        if (b == ";") begin
          if (is_amp || is_lt || is_gt || is_quot || is_apos) begin
            push = 1'b1;
            pbyte = is_amp ? "&" : is_lt ? "<" : is_gt ? ">" : is_quot ? "\"" : "'";
            if (can_push) begin
              in_ent_d = 1'b0; ent_len_d = '0;
            end
          end else if (is_nbsp) begin
            pend_d = sat_inc(pend_q); started_d = 1'b1; last_sp_d = 1'b0;
            in_ent_d = 1'b0; ent_len_d = '0;
          end else begin
            em_idx_d = '0;
            ret_d = (state_q == S_TAKE) ? S_END : S_REPLAY;
          end
        end else if (ent_len_q < EntLenW'(EntCap)) begin
          buf_we = 1'b1;
          ent_len_d = ent_len_q + 1'b1;
        end else begin
          // span exceeded (only from a fresh byte): emit '&' and replay
          push = 1'b1; pbyte = "&";
          if (can_push) begin
            rp_len_d = ent_len_q; rp_idx_d = '0;
            extra_d = b; extra_v_d = 1'b1;
            in_ent_d = 1'b0; ent_len_d = '0;
          end
        end
      end else if (b == "<") begin
        in_tag_d = 1'b1;
      end else if (b == ">" || (!in_tag_q && is_ws)) begin
        if (b == ">") in_tag_d = 1'b0;
        if (!last_sp_q && started_q) begin
          pend_d = sat_inc(pend_q); last_sp_d = 1'b1;
        end
      end else if (in_tag_q) begin
        in_tag_d = in_tag_q;
      end else if (b == "&") begin
        in_ent_d = 1'b1; ent_len_d = '0;
      end else begin
        push = 1'b1;
      end

      // advance the sequencer unless stalled on a push
      if (!push || can_push) begin
        if (state_q == S_REPLAY) begin
          if (rp_idx_q < rp_len_q) rp_idx_d = rp_idx_q + 1'b1;
          else extra_v_d = 1'b0;
        end
        if (in_ent_q && b == ";" && !(is_amp || is_lt || is_gt || is_quot || is_apos
            || is_nbsp)) begin
          state_d = S_EMIT;
        end else if (in_ent_q && b != ";" && ent_len_q >= EntLenW'(EntCap)) begin
          state_d = S_REPLAY;
        end else if (state_q == S_TAKE) begin
          state_d = S_END;
        end
      end else begin
        buf_we = 1'b0;
      end
    end

    if (push && can_push) begin
      // beyond the result cap the byte is dropped, the held item stays for the end mark
      if (res_cnt_q < ResCntW'(MaxResults)) begin
        if (hold_v_q) begin
          out_d = hold_q; out_v_d = 1'b1;
        end
        hold_d.out_byte = pbyte;
        hold_d.spaces_before = pend_q;
        hold_d.has_byte = 1'b1;
        hold_d.out_last = 1'b0;
        hold_v_d = 1'b1;
        res_cnt_d = res_cnt_q + 1'b1;
      end
      pend_d = '0; started_d = 1'b1; last_sp_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ret_q <= S_END;
      in_tag_q <= 1'b0; last_sp_q <= 1'b0; started_q <= 1'b0;
      in_ent_q <= 1'b0; pend_q <= '0; ent_len_q <= '0;
      rp_len_q <= '0; rp_idx_q <= '0; em_idx_q <= '0; extra_v_q <= 1'b0;
      res_cnt_q <= '0; hold_v_q <= 1'b0; out_v_q <= 1'b0; last_q <= 1'b0;
    end else begin
      state_q <= state_d; ret_q <= ret_d;
      in_tag_q <= in_tag_d; last_sp_q <= last_sp_d; started_q <= started_d;
      in_ent_q <= in_ent_d; pend_q <= pend_d; ent_len_q <= ent_len_d;
      rp_len_q <= rp_len_d; rp_idx_q <= rp_idx_d; em_idx_q <= em_idx_d;
      extra_v_q <= extra_v_d; res_cnt_q <= res_cnt_d; hold_v_q <= hold_v_d;
      out_v_q <= out_v_d; last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; extra_q <= extra_d; hold_q <= hold_d; out_q <= out_d;
    if (buf_we) buf_q[ent_len_q[EntIdxW-1:0]] <= buf_wdata;
  end

  `H2T_ASSERT_NOW(a_hold_empty_idle, state_q == S_IDLE, !hold_v_q, "item left in hold when idle")
  `H2T_ASSERT_NOW(a_ent_len_range, 1'b1, ent_len_q <= EntLenW'(EntCap), "entity length overflow")
  `H2T_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  `H2T_ASSERT_NOW(a_marker_is_last, out_v_q && !out_q.has_byte, out_q.out_last, "marker not last")

endmodule

>>> tb/html_to_plain_text_stream_tb.sv
// Testbench for the HTML to plain text stream block: directed and random documents.
`timescale 1ns / 100ps

module html_to_plain_text_stream_tb;
  import h2t_pkg::*;

  localparam int CycleLimit = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_o;

  html_to_plain_text_stream DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_i, .out_valid_o, .out_ready_i, .out_o
  );

  always #1 clk_i = ~clk_i;

  // Text predictor state
  logic        tag_open, space_seen, text_begun, ent_open;
  logic [15:0] space_cnt;
  logic [7:0]  ent_name [EntCap];
  int          ent_len;
  out_item_t   text_q [$];
  int          n_emitted;
  int          errors = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          cycles = 0;

  function automatic void clear_text_state();
    tag_open = 0; space_seen = 0; text_begun = 0; ent_open = 0;
    space_cnt = '0; ent_len = 0;
  endfunction

  function automatic void emit_char(logic [7:0] b);
    out_item_t r;
    if (n_emitted < MaxResults) begin
      r.out_byte = b; r.spaces_before = space_cnt; r.has_byte = 1'b1; r.out_last = 1'b0;
      text_q.insert(text_q.size(), r);
      n_emitted++;
    end
    space_cnt = '0; text_begun = 1; space_seen = 0;
  endfunction

  function automatic void bump_space();
    if (space_cnt != SpaceMax) space_cnt++;
  endfunction

  function automatic void fold_space();
    if (!space_seen && text_begun) begin
      bump_space();
      space_seen = 1;
    end
  endfunction

  function automatic bit name_eq(string s);
    if (ent_len != s.len()) return 0;
    for (int k = 0; k < s.len(); k++)
      if (ent_name[k] != s[k]) return 0;
    return 1;
  endfunction

  function automatic void close_entity();
    if (name_eq("amp")) emit_char("&");
    else if (name_eq("lt")) emit_char("<");
    else if (name_eq("gt")) emit_char(">");
    else if (name_eq("quot")) emit_char("\"");
    else if (name_eq("apos")) emit_char("'");
    else if (name_eq("nbsp")) begin
      bump_space();
      text_begun = 1;
    end else begin
      emit_char("&");
      for (int k = 0; k < ent_len; k++) emit_char(ent_name[k]);
      emit_char(";");
    end
    space_seen = 0; ent_open = 0; ent_len = 0;
  endfunction

  // Returns 1 when the entity span overflows on this byte.
  function automatic bit parse_byte(logic [7:0] b);
    if (ent_open) begin
      if (b == ";") begin
        close_entity();
        return 0;
      end
      if (ent_len < EntCap) begin
        ent_name[ent_len] = b;
        ent_len++;
        return 0;
      end
      return 1;
    end
    if (b == "<") tag_open = 1;
    else if (b == ">") begin
      tag_open = 0;
      fold_space();
    end else if (tag_open) ;
    else if (b == "&") begin
      ent_open = 1; ent_len = 0;
    end else if (b == " " || (b >= 9 && b <= 13)) fold_space();
    else emit_char(b);
    return 0;
  endfunction

  function automatic void give_up_entity(bit with_extra, logic [7:0] extra);
    logic [7:0] held [EntCap + 1];
    int n_held;
    n_held = 0;
    for (int k = 0; k < ent_len; k++) begin
      held[n_held] = ent_name[k];
      n_held++;
    end
    if (with_extra) begin
      held[n_held] = extra;
      n_held++;
    end
    ent_open = 0; ent_len = 0;
    emit_char("&");
    for (int k = 0; k < n_held; k++) void'(parse_byte(held[k]));
  endfunction

  function automatic void predict_item(in_item_t it);
    n_emitted = 0;
    if (parse_byte(it.in_byte)) give_up_entity(1, it.in_byte);
    if (it.in_last) begin
      for (int g = 0; ent_open && g <= MaxEntitySpan; g++) give_up_entity(0, 8'd0);
      if (n_emitted == 0) text_q.insert(text_q.size(), '{out_byte: 8'd0,
                                        spaces_before: 16'd0, has_byte: 1'b0,
                                        out_last: 1'b1});
      else text_q[text_q.size() - 1].out_last = 1'b1;
      clear_text_state();
    end
  endfunction

  // Valid stays up after an item until the next send or a drain.
  task automatic send_byte(logic [7:0] b, logic l);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= '{in_byte: b, in_last: l};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_item('{in_byte: b, in_last: l});
  endtask

  task automatic send_text(string s, bit close_doc);
    for (int k = 0; k < s.len(); k++) send_byte(s[k], close_doc && k == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (text_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver stall and result checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (text_q.size() == 0) begin
          $display("%0t unexpected result: actual %p", $time, out_o);
          errors++;
        end else begin
          if (out_o !== text_q[0]) begin
            $display("%0t mismatch: expected %p actual %p", $time, text_q[0], out_o);
            errors++;
          end
          void'(text_q.pop_front());
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_directed();
    string docs [$];
    docs = '{"  Hi <b>there</b>  world  ", "a&amp;b&lt;&gt;&quot;&apos;c",
             "x&nbsp;&nbsp;y", "&foo bar;z", "&;q", "p&abcdefghijklmno",
             "t&ab&amp;", "<p>unclosed <tag", "\t\n\r text\x0b\x0c end ", "&&&",
             "w&abcdefghijk;v", "    "};
    foreach (docs[i]) send_text(docs[i], 1);
    send_byte(8'hFF, 0);
    send_byte(8'h00, 1);
    send_byte(8'h80, 1);
    wait_drained();
  endtask

  task automatic test_random(int n_items);
    string frags [$];
    string s;
    frags = '{"&amp;", "&lt;", "&gt;", "&quot;", "&apos;", "&nbsp;", "<div>", "</a>",
              "  ", "\t", "word", "&zz;", "&", ";", "<", ">", "&longnameabcd"};
    for (int n = 0; n < n_items;) begin
      if ($urandom_range(3) == 0) begin
        send_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
        n++;
      end else begin
        s = frags[$urandom_range(frags.size() - 1)];
        for (int k = 0; k < s.len(); k++) begin
          send_byte(s[k], k == s.len() - 1 && $urandom_range(7) == 0);
          n++;
        end
      end
    end
    send_byte("e", 1);
  endtask

  initial begin
    clear_text_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(60);
    wait_drained();
    send_idle = 83;
    test_random(60);
    wait_drained();
    send_idle = 0; recv_stall = 83;
    test_random(60);
    wait_drained();
    send_idle = 13; recv_stall = 13;
    test_random(60);
    wait_drained();
    send_idle = 0; recv_stall = 0;
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
